@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// implication whose consequent is checked in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/ffra_pkg.sv @@
// ----------------------------------------------------------------------------
// ffra_pkg
// Types and constants shared by the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int MaxRanges = 64;
  localparam int IdxW      = $clog2(MaxRanges);
  localparam int CntW      = IdxW + 1;

  localparam logic [63:0] AllOnes = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam logic [1:0] OpAlloc   = 2'd0;
  localparam logic [1:0] OpFree    = 2'd1;
  localparam logic [1:0] OpReserve = 2'd2;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StNoFit   = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;
  localparam logic [1:0] StNoMatch = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] req_size;
    logic [63:0] req_addr;
    logic [63:0] req_end;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_addr;
    logic [1:0]  status;
  } out_word_t;

endpackage

@@ rtl/first_fit_range_allocator.sv @@
// A scan visits one table entry at a time: S_RD presents its address to the
// table RAM and S_EVAL evaluates the entry. An insert or removal moves one
// entry at a time through S_SHRD and S_SHWR. An allocate that fits scans the
// table a second time to find the insert point, unless its address lies below
// head_r and it goes to slot 0. The block takes no new word until the result
// word has been handed off. No clearing pass after reset.
// ----------------------------------------------------------------------------
// first_fit_range_allocator
// Sequenced first-fit allocator over an ordered range table held in RAM.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_range_allocator (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ffra_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ffra_pkg::out_word_t  out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [63:0]          cfg_data
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_RD    = 8'b0000_0010,  // address presented, wait for data
    S_EVAL  = 8'b0000_0100,  // evaluate entry i
    S_SHRD  = 8'b0000_1000,  // shift: read source entry
    S_SHWR  = 8'b0001_0000,  // shift: write destination entry
    S_INS   = 8'b0010_0000,
    S_DONE  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  localparam int IW = ffra_pkg::IdxW;
  localparam int CW = ffra_pkg::CntW;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic [63:0]     head_r;
  logic [1:0]      op_r, op_nxt;
  logic [63:0]     size_r, size_nxt, addr_r, addr_nxt, end_r, end_nxt;
  logic [63:0]     cur_end_r, cur_end_nxt;
  logic [63:0]     res_r, res_nxt;
  logic [1:0]      st_r, st_nxt;
  logic            ovalid_r, ovalid_nxt;
  logic [63:0]     shs_r, she_r;

  logic            we;
  logic [IW-1:0]   wa, ra;
  logic [63:0]     wds, wde, rds, rde;

  ffra_ram #(.Width(64), .Depth(ffra_pkg::MaxRanges)) u_starts (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wds), .rd_addr(ra), .rd_data(rds)
  );
  ffra_ram #(.Width(64), .Depth(ffra_pkg::MaxRanges)) u_ends (
    .clk(clk), .wr_en(we), .wr_addr(wa), .wr_data(wde), .rd_addr(ra), .rd_data(rde)
  );

  assign in_stall  = (state_r != S_IDLE) || ovalid_r;
  assign cfg_ready = (state_r == S_IDLE) && !ovalid_r;
  assign out_valid = ovalid_r;
  assign out_data  = '{result_addr: res_r, status: st_r};

  logic [63:0] nxt_start, gap;
  assign nxt_start = (i_r < cnt_r) ? rds : ffra_pkg::AllOnes;
  assign gap       = nxt_start - cur_end_r;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    i_nxt       = i_r;
    pos_nxt     = pos_r;
    op_nxt      = op_r;
    size_nxt    = size_r;
    addr_nxt    = addr_r;
    end_nxt     = end_r;
    cur_end_nxt = cur_end_r;
    res_nxt     = res_r;
    st_nxt      = st_r;
    ovalid_nxt  = ovalid_r && out_stall;
    we          = 1'b0;
    wa          = i_r[IW-1:0];
    wds         = shs_r;
    wde         = she_r;
    ra          = i_r[IW-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_valid && !ovalid_r) begin
          op_nxt      = in_data.op;
          size_nxt    = in_data.req_size;
          addr_nxt    = in_data.req_addr;
          end_nxt     = in_data.req_end;
          i_nxt       = '0;
          pos_nxt     = '0;
          cur_end_nxt = head_r;
          res_nxt     = '0;
          st_nxt      = ffra_pkg::StOk;
          case (in_data.op)
            ffra_pkg::OpAlloc: begin
              res_nxt   = ffra_pkg::AllOnes;
              st_nxt    = ffra_pkg::StNoFit;
              state_nxt = S_RD;
            end
            ffra_pkg::OpFree: state_nxt = S_RD;
            ffra_pkg::OpReserve: begin
              if (cnt_r >= CW'(ffra_pkg::MaxRanges)) begin
                st_nxt    = ffra_pkg::StFull;
                state_nxt = S_DONE;
              end else if (head_r <= in_data.req_addr) begin
                state_nxt = S_RD;
              end else begin
                i_nxt     = cnt_r;  // insert at 0
                state_nxt = (cnt_r == '0) ? S_INS : S_SHRD;
              end
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      S_RD: state_nxt = S_EVAL;
      S_EVAL: begin
        state_nxt = S_RD;
        i_nxt     = i_r + 1'b1;
        case (op_r)
          ffra_pkg::OpAlloc: begin
            cur_end_nxt = rde;
            if (gap >= size_r) begin
              // gap found; the insert point comes from a reserve-style scan
              addr_nxt = cur_end_r;
              end_nxt  = cur_end_r + size_r;
              if (cnt_r >= CW'(ffra_pkg::MaxRanges)) begin
                st_nxt    = ffra_pkg::StFull;
                state_nxt = S_DONE;
              end else begin
                res_nxt = cur_end_r;
                st_nxt  = ffra_pkg::StOk;
                op_nxt  = ffra_pkg::OpReserve;
                pos_nxt = '0;
                if (head_r <= cur_end_r) begin
                  i_nxt     = '0;
                  state_nxt = S_RD;
                end else begin
                  i_nxt     = cnt_r;
                  state_nxt = (cnt_r == '0) ? S_INS : S_SHRD;
                end
              end
            end else if (i_r >= cnt_r) begin
              state_nxt = S_DONE;
            end
          end
          ffra_pkg::OpFree: begin
            if (i_r >= cnt_r) begin
              st_nxt    = ffra_pkg::StNoMatch;
              state_nxt = S_DONE;
            end else if (rds == addr_r) begin
              cnt_nxt   = cnt_r - 1'b1;
              // pull entries down: dest i, source i+1
              state_nxt = (i_r + 1'b1 < cnt_r) ? S_SHRD : S_DONE;
              i_nxt     = i_r;
            end
          end
          default: begin  // reserve scan
            if (i_r < cnt_r && rde <= addr_r) begin
              pos_nxt = i_r + 1'b1;
            end else begin
              i_nxt     = cnt_r;
              state_nxt = (cnt_r == pos_r) ? S_INS : S_SHRD;
            end
          end
        endcase
      end
      S_SHRD: begin
        // up-shift (insert): dest i, source i-1; down-shift (free): dest i, source i+1
        ra        = (op_r == ffra_pkg::OpFree) ? IW'(i_r + 1'b1) : IW'(i_r - 1'b1);
        state_nxt = S_SHWR;
      end
      S_SHWR: begin
        we = 1'b1;
        wds = rds;
        wde = rde;
        if (op_r == ffra_pkg::OpFree) begin
          i_nxt     = i_r + 1'b1;
          state_nxt = (i_r + 2'd2 <= cnt_r) ? S_SHRD : S_DONE;
        end else begin
          i_nxt     = i_r - 1'b1;
          state_nxt = (i_r - 1'b1 > pos_r) ? S_SHRD : S_INS;
        end
      end
      S_INS: begin
        we        = 1'b1;
        wa        = pos_r[IW-1:0];
        wds       = addr_r;
        wde       = end_r;
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        ovalid_nxt = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cnt_r    <= '0;
      head_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      if (cfg_valid && cfg_ready) begin
        head_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r       <= i_nxt;
    pos_r     <= pos_nxt;
    op_r      <= op_nxt;
    size_r    <= size_nxt;
    addr_r    <= addr_nxt;
    end_r     <= end_nxt;
    cur_end_r <= cur_end_nxt;
    res_r     <= res_nxt;
    st_r      <= st_nxt;
    shs_r     <= rds;
    she_r     <= rde;
  end

  `ASSERT_IMPL(a_cnt_max, clk, rst_n, 1'b1, cnt_r <= CW'(ffra_pkg::MaxRanges))
  `ASSERT_IMPL(a_busy_no_out, clk, rst_n, state_r != S_IDLE && state_r != S_OUT, !ovalid_r)
  `ASSERT_NEXT(a_done_out, clk, rst_n, state_r == S_DONE, ovalid_r)

endmodule

@@ rtl/ffra_ram.sv @@
// ----------------------------------------------------------------------------
// ffra_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffra_ram #(
  parameter int Width = 64,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(Depth)-1:0] wr_addr,
  input  logic [Width-1:0]         wr_data,
  input  logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]         rd_data
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
